// ===== rtl/tlbt_pkg.sv =====
// Shared types and constants for the TLB page table translator.
// No dependencies; every other file of the block but tlbt_ram imports this package.
`default_nettype none

package tlbt_pkg;

    // Fixed widths of the channel payloads.
    localparam int VA_W  = 16;
    localparam int PA_W  = 16;
    localparam int CNT_W = 32;

    // TLB tag and frame slots are at most byte-wide stores.
    localparam int TLB_FIELD_W = 8;

    // Default geometry.
    localparam int TLB_ENTRIES_DEF = 16;
    localparam int PAGE_BITS_DEF   = 8;
    localparam int OFFSET_BITS_DEF = 8;

    // Control sequence of the translator.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/tlbt_if.sv =====
// Valid/ready channel interfaces for the translator's input and result.
// Depends on tlbt_pkg for the payload widths.
`default_nettype none

interface tlbt_va_if import tlbt_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [VA_W-1:0] virtual_address;

    modport source (output valid, output virtual_address, input ready);
    modport sink   (input valid, input virtual_address, output ready);
endinterface

interface tlbt_res_if import tlbt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PA_W-1:0]  physical_address;
    logic             tlb_hit;
    logic             pt_fault;
    logic [CNT_W-1:0] lookup_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] fault_total;

    modport source (output valid, output physical_address, output tlb_hit,
                    output pt_fault, output lookup_total, output miss_total,
                    output fault_total, input ready);
    modport sink   (input valid, input physical_address, input tlb_hit,
                    input pt_fault, input lookup_total, input miss_total,
                    input fault_total, output ready);
endinterface

`default_nettype wire

// ===== rtl/tlbt_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`default_nettype none

module tlbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, or read into the output register; the data holds otherwise.
    always_ff @(posedge i_clk) begin
        if (i_en && i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else if (i_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/tlbt_cam.sv =====
// Fully associative TLB: tag and frame slots, valid bits, FIFO replacement.
// Depends on tlbt_pkg for the slot width.
`default_nettype none

module tlbt_cam import tlbt_pkg::*; #(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
    parameter int PAGE_BITS   = PAGE_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [PAGE_BITS-1:0] i_page,
    output      logic                 o_hit,
    output      logic [PAGE_BITS-1:0] o_frame,
    input  wire logic                 i_fill_en,
    input  wire logic [PAGE_BITS-1:0] i_fill_page,
    input  wire logic [PAGE_BITS-1:0] i_fill_frame
);

    // Slots hold at most a byte of the page and of the frame.
    localparam int TAG_W = (PAGE_BITS < TLB_FIELD_W) ? PAGE_BITS : TLB_FIELD_W;
    localparam int PTR_W = $clog2(TLB_ENTRIES);

    logic [TAG_W-1:0]       r_tag   [TLB_ENTRIES];
    logic [TAG_W-1:0]       r_frame [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] r_valid;
    logic [PTR_W-1:0]       r_ptr;
    logic [PTR_W-1:0]       n_ptr;
    logic                   hi_zero;

    // A page wider than a slot can never match its truncated tag.
    assign hi_zero = ((i_page >> TAG_W) == '0);

    // Parallel compare; the lowest matching slot takes priority.
    always_comb begin
        o_hit   = 1'b0;
        o_frame = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && hi_zero && (r_tag[i] == TAG_W'(i_page))) begin
                o_hit   = 1'b1;
                o_frame = PAGE_BITS'(r_frame[i]);
            end
        end
    end

    // The replacement pointer wraps after the last slot.
    always_comb begin
        if (r_ptr == PTR_W'(TLB_ENTRIES - 1)) begin
            n_ptr = '0;
        end else begin
            n_ptr = r_ptr + 1'b1;
        end
    end

    // Control state: valid bits and pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ptr   <= '0;
        end else if (i_fill_en) begin
            r_valid[r_ptr] <= 1'b1;
            r_ptr          <= n_ptr;
        end
    end

    // Slot payload is written only on a fill.
    always_ff @(posedge i_clk) begin
        if (i_fill_en) begin
            r_tag[r_ptr]   <= TAG_W'(i_fill_page);
            r_frame[r_ptr] <= TAG_W'(i_fill_frame);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tlb_page_table_translator_unit.sv =====
// Top level of the TLB page table translator.
// Depends on tlbt_pkg, tlbt_if, tlbt_ram and tlbt_cam.
`default_nettype none

// Usage:
// i_va carries one virtual address per transfer; o_res returns exactly one
// result per address: the physical address, the TLB hit and page fault
// flags, and running 32-bit counts of lookups, misses and faults.
// Each address passes through ST_IDLE and ST_LOOK: when it is accepted the TLB tags are
// compared in parallel while the page table entry is read from its
// single-port RAM; in ST_LOOK the entry is resolved, a fault
// assigns the next free frame and writes the entry back, the TLB slot at
// the replacement pointer is filled on a miss, and the result is loaded
// into the output register. A new address is accepted only after that,
// so addresses are looked up one at a time and never overlap, as the RAM
// serves each read and then its write-back in turn.
// After reset the page table RAM is swept clear, one entry per cycle, over
// all 2^PAGE_BITS entries (256 by default); no address is accepted meanwhile.
// The output register holds a result until it is taken. A new address may
// be accepted while it waits; that address then stops in ST_LOOK,
// with no state changed, until the register is free.

module tlb_page_table_translator_unit import tlbt_pkg::*; #(
    parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
    parameter int PAGE_BITS   = PAGE_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tlbt_va_if.sink    i_va,
    tlbt_res_if.source o_res
);

    localparam int PAGE_COUNT = 1 << PAGE_BITS;
    localparam int ENT_W      = PAGE_BITS + 1;
    localparam int X_W        = (PAGE_BITS + OFFSET_BITS > VA_W) ?
                                (PAGE_BITS + OFFSET_BITS) : VA_W;

    t_state r_state;
    t_state n_state;

    logic [PAGE_BITS-1:0] r_clr;
    logic [VA_W-1:0]      r_va;
    logic                 r_hit;
    logic [PAGE_BITS-1:0] r_tlb_frame;
    logic [PAGE_BITS:0]   r_next_free;
    logic [CNT_W-1:0]     r_lookups;
    logic [CNT_W-1:0]     r_misses;
    logic [CNT_W-1:0]     r_faults;

    logic                 r_out_valid;
    logic [PA_W-1:0]      r_out_pa;
    logic                 r_out_hit;
    logic                 r_out_fault;

    logic                 accept;
    logic                 commit;
    logic                 in_ready;
    logic [PAGE_BITS-1:0] in_page;
    logic [PAGE_BITS-1:0] cur_page;
    logic [OFFSET_BITS-1:0] cur_off;
    logic                 cam_hit;
    logic [PAGE_BITS-1:0] cam_frame;

    logic                 ram_en;
    logic                 ram_we;
    logic [PAGE_BITS-1:0] ram_addr;
    logic [ENT_W-1:0]     ram_wdata;
    logic [ENT_W-1:0]     ram_rdata;

    logic                 ent_valid;
    logic                 fault;
    logic [PAGE_BITS-1:0] frame;
    logic [X_W-1:0]       pa_x;

    // Split the incoming and the held address into page and offset.
    assign in_page  = PAGE_BITS'(X_W'(i_va.virtual_address) >> OFFSET_BITS);
    assign cur_page = PAGE_BITS'(X_W'(r_va) >> OFFSET_BITS);
    assign cur_off  = OFFSET_BITS'(X_W'(r_va));

    assign accept = i_va.valid && in_ready;
    assign commit = (r_state == ST_LOOK) && (!r_out_valid || o_res.ready);

    // TLB search runs on the incoming page; fills come at commit.
    tlbt_cam #(
        .TLB_ENTRIES (TLB_ENTRIES),
        .PAGE_BITS   (PAGE_BITS)
    ) u_cam (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_page       (in_page),
        .o_hit        (cam_hit),
        .o_frame      (cam_frame),
        .i_fill_en    (commit && !r_hit),
        .i_fill_page  (cur_page),
        .i_fill_frame (frame)
    );

    // Page table entries: a valid bit above the frame number.
    tlbt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (PAGE_COUNT)
    ) u_pt_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Resolve the entry read in the accept cycle.
    assign ent_valid = ram_rdata[PAGE_BITS];
    assign fault     = !r_hit && !ent_valid;

    always_comb begin
        if (r_hit) begin
            frame = r_tlb_frame;
        end else if (ent_valid) begin
            frame = ram_rdata[PAGE_BITS-1:0];
        end else begin
            frame = r_next_free[PAGE_BITS-1:0];
        end
    end

    assign pa_x = (X_W'(frame) << OFFSET_BITS) | X_W'(cur_off);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == PAGE_BITS'(PAGE_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // State outputs: input handshake and page table RAM control.
    always_comb begin
        in_ready  = 1'b0;
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = cur_page;
        ram_wdata = '0;
        case (r_state)
            ST_CLEAR: begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = r_clr;
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                ram_en   = i_va.valid;
                ram_addr = in_page;
            end
            ST_LOOK: begin
                ram_en    = commit && fault;
                ram_we    = commit && fault;
                ram_wdata = {1'b1, r_next_free[PAGE_BITS-1:0]};
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Control state, counters and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_next_free <= '0;
            r_lookups   <= '0;
            r_misses    <= '0;
            r_faults    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (commit) begin
                r_lookups <= r_lookups + 1'b1;
                if (!r_hit) begin
                    r_misses <= r_misses + 1'b1;
                end
                if (fault) begin
                    r_faults    <= r_faults + 1'b1;
                    r_next_free <= r_next_free + 1'b1;
                end
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: the held address, the TLB answer and the result.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_va        <= i_va.virtual_address;
            r_hit       <= cam_hit;
            r_tlb_frame <= cam_frame;
        end
        if (commit) begin
            r_out_pa    <= PA_W'(pa_x);
            r_out_hit   <= r_hit;
            r_out_fault <= fault;
        end
    end

    assign i_va.ready             = in_ready;
    assign o_res.valid            = r_out_valid;
    assign o_res.physical_address = r_out_pa;
    assign o_res.tlb_hit          = r_out_hit;
    assign o_res.pt_fault         = r_out_fault;
    assign o_res.lookup_total     = r_lookups;
    assign o_res.miss_total       = r_misses;
    assign o_res.fault_total      = r_faults;

endmodule

`default_nettype wire

// ===== verif/tb_tlb_page_table_translator_unit.sv =====
// Self-checking testbench for the TLB page table translator: drives virtual addresses and
// checks every result against a built-in translation predictor. Depends on tlbt_pkg, the
// channel interfaces in tlbt_if and the top level tlb_page_table_translator_unit.
`timescale 1ns / 100ps

module tb_tlb_page_table_translator_unit;
    import tlbt_pkg::*;

    localparam int N_SLOTS = TLB_ENTRIES_DEF;
    localparam int PG_W    = PAGE_BITS_DEF;
    localparam int OFS_W   = OFFSET_BITS_DEF;
    localparam int N_PAGES = 1 << PG_W;
    localparam int PTR_W   = $clog2(N_SLOTS);

    // One predicted translation, field for field as on the result channel.
    typedef struct packed {
        logic [PA_W-1:0]  physical_address;
        logic             tlb_hit;
        logic             pt_fault;
        logic [CNT_W-1:0] lookup_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] fault_total;
    } t_xlate;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tlbt_va_if  va_bus ();
    tlbt_res_if res_bus ();

    tlb_page_table_translator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_va    (va_bus),
        .o_res   (res_bus)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state: TLB slots, page table and running counts.
    logic [PG_W-1:0]  tlb_tag_m   [N_SLOTS];
    logic [PG_W-1:0]  tlb_frame_m [N_SLOTS];
    bit               tlb_valid_m [N_SLOTS];
    logic [PTR_W-1:0] fifo_ptr_m;
    logic [PG_W-1:0]  pt_frame_m  [N_PAGES];
    bit               pt_valid_m  [N_PAGES];
    logic [PG_W:0]    free_frame_m;
    logic [CNT_W-1:0] lookups_m;
    logic [CNT_W-1:0] misses_m;
    logic [CNT_W-1:0] faults_m;

    t_xlate pending_xlates[$];
    int     mismatch_cnt = 0;

    // Stall controls shared between the test sequence and the result receiver.
    bit src_idle_en;
    bit res_idle_en;
    bit res_hold;
    int res_wait = 0;

    // Clear the predictor to its state after reset.
    function automatic void clear_translator_model();
        foreach (tlb_valid_m[i]) begin
            tlb_valid_m[i] = 1'b0;
            tlb_tag_m[i]   = '0;
            tlb_frame_m[i] = '0;
        end
        foreach (pt_valid_m[i]) begin
            pt_valid_m[i] = 1'b0;
            pt_frame_m[i] = '0;
        end
        fifo_ptr_m   = '0;
        free_frame_m = '0;
        lookups_m    = '0;
        misses_m     = '0;
        faults_m     = '0;
    endfunction

    // Translate one address and update the predictor as the block should.
    function automatic t_xlate translate_va(input logic [VA_W-1:0] va);
        t_xlate          r;
        logic [PG_W-1:0] pg;
        logic [PG_W-1:0] frm;
        bit              found;
        pg    = va[OFS_W +: PG_W];
        frm   = '0;
        found = 1'b0;
        r     = '0;
        lookups_m = lookups_m + 1'b1;
        // The lowest valid matching slot wins.
        for (int i = 0; i < N_SLOTS; i++) begin
            if (!found && tlb_valid_m[i] && tlb_tag_m[i] == pg) begin
                found = 1'b1;
                frm   = tlb_frame_m[i];
            end
        end
        if (!found) begin
            misses_m = misses_m + 1'b1;
            // Demand paging: an invalid entry takes the next free frame.
            if (!pt_valid_m[pg]) begin
                pt_frame_m[pg] = free_frame_m[PG_W-1:0];
                pt_valid_m[pg] = 1'b1;
                free_frame_m   = free_frame_m + 1'b1;
                faults_m       = faults_m + 1'b1;
                r.pt_fault     = 1'b1;
            end
            frm = pt_frame_m[pg];
            tlb_tag_m[fifo_ptr_m]   = pg;
            tlb_frame_m[fifo_ptr_m] = frm;
            tlb_valid_m[fifo_ptr_m] = 1'b1;
            fifo_ptr_m = fifo_ptr_m + 1'b1;
        end
        r.physical_address = {frm, va[OFS_W-1:0]};
        r.tlb_hit          = found;
        r.lookup_total     = lookups_m;
        r.miss_total       = misses_m;
        r.fault_total      = faults_m;
        return r;
    endfunction

    // Offer one address, wait for its transfer and record the predicted result.
    task automatic send_va(input logic [VA_W-1:0] va);
        int gap;
        gap = src_idle_en ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            va_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        va_bus.valid           <= 1'b1;
        va_bus.virtual_address <= va;
        do @(posedge i_clk); while (!va_bus.ready);
        pending_xlates.push_back(translate_va(va));
    endtask

    // Stop offering and wait until every predicted result has been taken.
    task automatic wait_drained();
        va_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_xlates.size() != 0) @(posedge i_clk);
    endtask

    function automatic void cmp_field(input string name, input logic [CNT_W-1:0] exp_v,
                                      input logic [CNT_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            mismatch_cnt++;
        end
    endfunction

    // Compare one result transfer with the oldest prediction.
    function automatic void check_result();
        t_xlate e;
        if (pending_xlates.size() == 0) begin
            $error("unexpected result: physical_address 0x%0h", res_bus.physical_address);
            mismatch_cnt++;
            return;
        end
        e = pending_xlates.pop_front();
        cmp_field("physical_address", CNT_W'(e.physical_address),
                  CNT_W'(res_bus.physical_address));
        cmp_field("tlb_hit", CNT_W'(e.tlb_hit), CNT_W'(res_bus.tlb_hit));
        cmp_field("pt_fault", CNT_W'(e.pt_fault), CNT_W'(res_bus.pt_fault));
        cmp_field("lookup_total", e.lookup_total, res_bus.lookup_total);
        cmp_field("miss_total", e.miss_total, res_bus.miss_total);
        cmp_field("fault_total", e.fault_total, res_bus.fault_total);
    endfunction

    // Result receiver: checks each transfer and then stalls for a random number of cycles.
    initial begin
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                res_bus.ready <= 1'b0;
            end else begin
                if (res_bus.valid && res_bus.ready) begin
                    check_result();
                    res_wait = res_idle_en ? $urandom_range(0, 4) : 0;
                end
                if (res_hold) begin
                    res_bus.ready <= 1'b0;
                end else if (res_wait > 0) begin
                    res_wait--;
                    res_bus.ready <= 1'b0;
                end else begin
                    res_bus.ready <= 1'b1;
                end
            end
        end
    end

    // Extremes of the address, hits, faults, and a miss on a page that was evicted
    // from the TLB but is still valid in the page table.
    task automatic test_directed();
        send_va(16'h0000);
        send_va(16'h00FF);
        send_va(16'hFFFF);
        send_va(16'hFF00);
        send_va(16'hAA55);
        send_va(16'h55AA);
        // Thirteen more pages overrun the sixteen slots and evict page zero.
        for (int p = 1; p <= 13; p++) send_va({PG_W'(p), OFS_W'($urandom)});
        send_va(16'h0080);
        send_va(16'hFF80);
        send_va(16'h0D7F);
    endtask

    // Mostly a shifting hot set of pages, so that hits, refills and faults all occur.
    task automatic test_random_traffic(input int n);
        logic [PG_W-1:0] hot_pages[24];
        int              hot_n;
        logic [PG_W-1:0] pg;
        hot_n = 1;
        for (int k = 0; k < n; k++) begin
            if (k % 64 == 0) begin
                hot_n = $urandom_range(4, 24);
                foreach (hot_pages[i]) hot_pages[i] = PG_W'($urandom);
            end
            if ($urandom_range(0, 99) < 75) pg = hot_pages[$urandom_range(0, hot_n - 1)];
            else pg = PG_W'($urandom);
            send_va({pg, OFS_W'($urandom)});
        end
    endtask

    // A stretch with no idling on either side.
    task automatic test_back_to_back(input int n);
        src_idle_en = 1'b0;
        res_idle_en <= 1'b0;
        test_random_traffic(n);
        src_idle_en = 1'b1;
        res_idle_en <= 1'b1;
    endtask

    // The receiver holds off long enough for the block to fill and stall its input.
    task automatic test_result_backpressure();
        src_idle_en = 1'b0;
        fork
            begin
                @(posedge i_clk);
                res_hold <= 1'b1;
                repeat (80) @(posedge i_clk);
                res_hold <= 1'b0;
            end
        join_none
        test_random_traffic(24);
        wait_drained();
        src_idle_en = 1'b1;
    endtask

    // Every page once in shuffled order, so that all frames are handed out.
    task automatic test_page_sweep();
        int order[N_PAGES];
        int j;
        int t;
        foreach (order[i]) order[i] = i;
        for (int i = N_PAGES - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        foreach (order[i]) send_va({PG_W'(order[i]), OFS_W'($urandom)});
    endtask

    // Main sequence.
    initial begin
        int guard;
        va_bus.valid           <= 1'b0;
        va_bus.virtual_address <= '0;
        i_rst_n                <= 1'b0;
        res_hold               <= 1'b0;
        res_idle_en            <= 1'b1;
        src_idle_en = 1'b1;
        clear_translator_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_traffic(400);
        test_back_to_back(100);
        test_result_backpressure();
        test_page_sweep();
        test_random_traffic(170);

        // Drain the outstanding translations, then allow a few cycles for strays.
        va_bus.valid <= 1'b0;
        guard = 0;
        while (pending_xlates.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_xlates.size() != 0) begin
            $error("%0d translations never returned", pending_xlates.size());
            mismatch_cnt++;
        end
        repeat (16) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
